FILE: src/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg: shared types and constants of the windowed median filter
// Holds default build sizes, register map codes, the controller state type
// and the command group passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package wmf_pkg;

  // Default build sizes.
  localparam int MAX_WINDOW_DEFAULT  = 32;
  localparam int SAMPLE_BITS_DEFAULT = 12;

  // Configuration register map.
  localparam int              WS_BITS          = 6;
  localparam int              CFG_ADDR_W       = 3;
  localparam int              CFG_DATA_W       = 32;
  localparam logic [0:0]      REG_WINDOW_SIZE  = 1'b0;
  localparam logic [WS_BITS-1:0] WINDOW_SIZE_RESET = 6'd16;

  // Controller states.
  typedef enum logic [0:0] {
    CtrlIdle,
    CtrlShift
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;  // insert in sorted order, up to the current fill position
    logic shift;   // move every cell one place toward cell 0
    logic emit;    // register the result from cells 0 and 1
    logic odd;     // window count is odd: result is cell 0 doubled
  } dp_cmd_t;

endpackage

FILE: src/wmf_ctrl.sv
// ----------------------------------------------------------------------------
// wmf_ctrl: controller of the windowed median filter
// Tracks the fill count, decides when a window closes and sequences the
// shifts that bring the middle samples down to cell 0 before the result.
// ----------------------------------------------------------------------------
module wmf_ctrl #(
  parameter int MAX_WINDOW = 32,
  parameter int CW         = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wmf_pkg::WS_BITS-1:0]   window_size_i,
  output logic                          busy_o,
  output wmf_pkg::dp_cmd_t              cmd_o,
  output logic [CW-1:0]                 ins_pos_o
);
  import wmf_pkg::*;

  localparam int WW = (CW > WS_BITS) ? CW : WS_BITS;

  ctrl_state_e   state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] shift_q, shift_d;
  logic          odd_q, odd_d;

  logic          accept;
  logic [WW-1:0] ws_w;
  logic [WW-1:0] n_eff;
  logic [WW-1:0] cnt_inc;
  logic          close;

  assign accept  = start_i && (state_q == CtrlIdle);
  assign ws_w    = WW'(window_size_i);
  // Zero acts as one; saturate to the built capacity.
  assign n_eff   = (ws_w == '0) ? WW'(1) :
                   ((ws_w > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : ws_w);
  assign cnt_inc = WW'(count_q) + WW'(1);
  assign close   = (cnt_inc >= n_eff);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      CtrlIdle: begin
        if (accept && close) begin
          state_d = CtrlShift;
        end
      end
      CtrlShift: begin
        if (shift_q == '0) begin
          state_d = CtrlIdle;
        end
      end
      default: state_d = CtrlIdle;
    endcase
  end

  // Counters.
  always_comb begin
    count_d = count_q;
    shift_d = shift_q;
    odd_d   = odd_q;
    if (accept) begin
      if (close) begin
        count_d = '0;
        shift_d = count_q >> 1;
        odd_d   = ~count_q[0];
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if ((state_q == CtrlShift) && (shift_q != '0)) begin
      shift_d = shift_q - CW'(1);
    end
  end

  // Outputs.
  always_comb begin
    cmd_o        = '0;
    busy_o       = 1'b0;
    cmd_o.insert = accept;
    cmd_o.odd    = odd_q;
    case (state_q)
      CtrlIdle: begin
        busy_o = 1'b0;
      end
      CtrlShift: begin
        busy_o     = 1'b1;
        cmd_o.shift = (shift_q != '0);
        cmd_o.emit  = (shift_q == '0);
      end
      default: busy_o = 1'b1;
    endcase
  end

  assign ins_pos_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtrlIdle;
      count_q <= '0;
      shift_q <= '0;
      odd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      shift_q <= shift_d;
      odd_q   <= odd_d;
    end
  end

endmodule

FILE: src/wmf_dp.sv
// ----------------------------------------------------------------------------
// wmf_dp: datapath of the windowed median filter
// A chain of sorting cells that, outside shifts, inserts one sample per cycle
// ascending, shifts toward cell 0 on command and registers the doubled median.
// ----------------------------------------------------------------------------
module wmf_dp #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 12,
  parameter int CW          = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wmf_pkg::dp_cmd_t        cmd_i,
  input  logic [CW-1:0]           ins_pos_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic                    median_valid_o,
  output logic [SAMPLE_BITS:0]    median_doubled_o
);
  import wmf_pkg::*;

  localparam int SECOND = (MAX_WINDOW > 1) ? 1 : 0;

  logic [SAMPLE_BITS-1:0] cell_q [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cell_d [MAX_WINDOW];
  logic                   valid_q;
  logic [SAMPLE_BITS:0]   median_q;
  logic [SAMPLE_BITS:0]   sum;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic at_end;
    logic in_range;
    assign at_end   = (ins_pos_i == CW'(i));
    assign in_range = (CW'(i) <= ins_pos_i);

    if (i == 0) begin : g_first
      always_comb begin
        cell_d[i] = cell_q[i];
        if (cmd_i.insert) begin
          if (at_end || (cell_q[i] > sample_i)) begin
            cell_d[i] = sample_i;
          end
        end else if (cmd_i.shift) begin
          cell_d[i] = cell_q[SECOND];
        end
      end
    end else begin : g_rest
      always_comb begin
        cell_d[i] = cell_q[i];
        if (cmd_i.insert) begin
          if (in_range) begin
            // Larger neighbors move up one place; the sample lands at the gap.
            if (cell_q[i-1] > sample_i) begin
              cell_d[i] = cell_q[i-1];
            end else if (at_end || (cell_q[i] > sample_i)) begin
              cell_d[i] = sample_i;
            end
          end
        end else if (cmd_i.shift && (i < MAX_WINDOW - 1)) begin
          cell_d[i] = cell_q[(i < MAX_WINDOW - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  // Odd count: middle sample doubled; even: sum of the two middle samples.
  assign sum = {1'b0, cell_q[0]} +
               (cmd_i.odd ? {1'b0, cell_q[0]} : {1'b0, cell_q[SECOND]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      median_q <= sum;
    end
  end

  assign median_valid_o   = valid_q;
  assign median_doubled_o = median_q;

endmodule

FILE: src/windowed_median_filter.sv
// ----------------------------------------------------------------------------
// windowed_median_filter: median of a configurable window of samples
// Collects samples in sorted order; when the window is full it gives twice
// the median (half-LSB fixed point) and starts a new window.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                         Direction  Beat
//  -------   --------------------------------------------  ---------  -----------------------
//  sample    start_i, busy_o, sample_i                     in         start_i && !busy_o
//  result    median_valid_o, median_doubled_o              out        median_valid_o (1 cycle)
//  config    psel_i, penable_i, pwrite_i, paddr_i,         in/out     psel & penable & pwrite
//            pwdata_i, prdata_o, pready_o
//
//  A sample that does not close a window leaves busy_o low.
//  A sample that closes a window holds busy_o high while the cell chain
//  shifts one place per cycle until the middle samples sit in cells 0 and 1,
//  and while the result is registered. The result beat follows on the cycle
//  after busy_o's last high cycle, as busy_o drops.
//  Reset (rst_ni low, asynchronous) empties the window and sets window_size
//  to 16. The receiver cannot stall: each result is shown for one cycle.
//
module windowed_median_filter #(
  parameter int MAX_WINDOW  = wmf_pkg::MAX_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = wmf_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Sample channel
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [SAMPLE_BITS-1:0]             sample_i,
  // Result channel
  output logic                               median_valid_o,
  output logic [SAMPLE_BITS:0]               median_doubled_o,
  // Configuration port
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [wmf_pkg::CFG_ADDR_W-1:0]     paddr_i,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]     pwdata_i,
  output logic [wmf_pkg::CFG_DATA_W-1:0]     prdata_o,
  output logic                               pready_o
);
  import wmf_pkg::*;

  // Fill count must hold MAX_WINDOW itself.
  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [WS_BITS-1:0] window_size_q, window_size_d;
  logic               cfg_write;
  logic [0:0]         reg_index;
  dp_cmd_t            cmd;
  logic [CW-1:0]      ins_pos;

  // Configuration: word address in the upper paddr bits, byte offset ignored.
  assign reg_index = paddr_i[CFG_ADDR_W-1:2];
  assign cfg_write = psel_i && penable_i && pwrite_i;
  assign pready_o  = 1'b1;

  always_comb begin
    window_size_d = window_size_q;
    if (cfg_write && (reg_index == REG_WINDOW_SIZE)) begin
      window_size_d = pwdata_i[WS_BITS-1:0];
    end
  end

  // Read back the register; unmapped words read as zero.
  always_comb begin
    prdata_o = '0;
    if (reg_index == REG_WINDOW_SIZE) begin
      prdata_o = CFG_DATA_W'(window_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RESET;
    end else begin
      window_size_q <= window_size_d;
    end
  end

  // Controller: fill count, window close and shift sequencing.
  wmf_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .window_size_i (window_size_q),
    .busy_o        (busy_o),
    .cmd_o         (cmd),
    .ins_pos_o     (ins_pos)
  );

  // Datapath: sorting cell chain and result register.
  wmf_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .ins_pos_i        (ins_pos),
    .sample_i         (sample_i),
    .median_valid_o   (median_valid_o),
    .median_doubled_o (median_doubled_o)
  );

endmodule

FILE: tb/sv/wmf_checker.sv
// ----------------------------------------------------------------------------
// wmf_checker: scoreboard for the windowed median filter
// Watches the sample, result and register channels. Keeps its own sorted
// window and register copy, works out each due median when a sample beat
// closes a window, and compares every result beat with the oldest one due.
// ----------------------------------------------------------------------------
module wmf_checker
  import wmf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                  median_valid_i,
  input  logic [SAMPLE_BITS:0]  median_doubled_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [CFG_DATA_W-1:0] pwdata_i,
  input  logic [CFG_DATA_W-1:0] prdata_i,
  input  logic                  pready_i,
  output int                    err_count_o,
  output int                    pending_o
);

  localparam logic [CFG_ADDR_W-1:0] WS_ADDR = CFG_ADDR_W'(4 * REG_WINDOW_SIZE);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS:0]   median_t;

  sample_t            held_samples[$];  // current window, ascending
  median_t            medians_due[$];
  logic [WS_BITS-1:0] window_size_q = WINDOW_SIZE_RESET;
  int                 errors = 0;

  function automatic int window_limit(logic [WS_BITS-1:0] ws);
    if (ws == '0) return 1;
    if (ws > MAX_WINDOW) return MAX_WINDOW;
    return int'(ws);
  endfunction

  task automatic report_mismatch(string msg);
    $display("wmf_checker: %s", msg);
    errors++;
  endtask

  // Insert the sample in order; close the window once it is full.
  task automatic take_sample(sample_t s);
    int      pos;
    int      cnt;
    int      mid;
    median_t m;
    if (held_samples.size() < MAX_WINDOW) begin
      pos = held_samples.size();
      while (pos > 0 && held_samples[pos-1] > s) pos--;
      held_samples.insert(pos, s);
    end
    cnt = held_samples.size();
    if (cnt >= window_limit(window_size_q)) begin
      mid = cnt / 2;
      if (cnt % 2 == 0) begin
        m = median_t'(held_samples[mid-1]) + median_t'(held_samples[mid]);
      end else begin
        m = {held_samples[mid], 1'b0};
      end
      medians_due.push_back(m);
      held_samples.delete();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    median_t want;
    if (!rst_ni) begin
      held_samples.delete();
      medians_due.delete();
      window_size_q = WINDOW_SIZE_RESET;
      pending_o   <= 0;
      err_count_o <= errors;
    end else begin
      // A result can never belong to a sample taken at the same edge.
      if (median_valid_i) begin
        if (medians_due.size() == 0) begin
          report_mismatch($sformatf("median %0d with none due", median_doubled_i));
        end else begin
          want = medians_due.pop_front();
          if (median_doubled_i !== want) begin
            report_mismatch($sformatf("median_doubled got %0d want %0d",
                                      median_doubled_i, want));
          end
        end
      end
      if (psel_i && penable_i && pready_i && paddr_i == WS_ADDR) begin
        if (pwrite_i) begin
          window_size_q = pwdata_i[WS_BITS-1:0];
        end else if (prdata_i !== CFG_DATA_W'(window_size_q)) begin
          report_mismatch($sformatf("window_size read got %0d want %0d",
                                    prdata_i, window_size_q));
        end
      end
      if (start_i && !busy_i) take_sample(sample_i);
      pending_o   <= medians_due.size();
      err_count_o <= errors;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the windowed median filter
// Drives sample beats and register writes into the filter; a checker beside
// it predicts each median and compares. A short directed part covers the
// field extremes and the window corner cases, then random phases run with
// random window sizes, sample patterns and sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import wmf_pkg::*;

  localparam int          ITEMS       = 650;
  localparam int          DRAIN       = 24;      // longer than the longest busy stretch
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_ADDR_W-1:0] WS_ADDR = CFG_ADDR_W'(4 * REG_WINDOW_SIZE);

  typedef logic [SAMPLE_BITS_DEFAULT-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = '1;

  logic                          clk     = 1'b0;
  logic                          rst_n   = 1'b0;
  logic                          start   = 1'b0;
  logic                          busy;
  sample_t                       sample  = '0;
  logic                          median_valid;
  logic [SAMPLE_BITS_DEFAULT:0]  median_doubled;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]         paddr   = '0;
  logic [CFG_DATA_W-1:0]         pwdata  = '0;
  logic [CFG_DATA_W-1:0]         prdata;
  logic                          pready;
  int                            err_count;
  int                            pending;
  int unsigned                   cycles = 0;

  always #6 clk = ~clk;

  windowed_median_filter dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .sample_i         (sample),
    .median_valid_o   (median_valid),
    .median_doubled_o (median_doubled),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_o         (prdata),
    .pready_o         (pready)
  );

  wmf_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .sample_i         (sample),
    .median_valid_i   (median_valid),
    .median_doubled_i (median_doubled),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  // Watchdog: a lost result or a stuck busy ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Drop start and put noise on the idle sample bus.
  task automatic idle_cycles(int n);
    repeat (n) begin
      start  <= 1'b0;
      sample <= sample_t'($urandom());
      @(posedge clk);
    end
  endtask

  // Offer one sample beat and hold it until the filter takes it.
  // start stays high on return so back-to-back beats need no re-raise.
  task automatic push_sample(sample_t v);
    start  <= 1'b1;
    sample <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Wait until every due median has come out, then let the datapath settle.
  // The first edge lets the checker count the last accepted beat.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(bit wr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WS_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change the window between phases; junk above the field must be dropped.
  task automatic set_window(logic [WS_BITS-1:0] ws);
    logic [CFG_DATA_W-1:0] data;
    data          = $urandom();
    data[WS_BITS-1:0] = ws;
    wait_idle();
    cfg_access(1'b1, data);
    if ($urandom_range(0, 2) == 0) cfg_access(1'b0, '0);
  endtask

  // Mostly no gap, some short gaps, a few long ones.
  task automatic sender_gap(bit burst);
    int r;
    if (burst) return;
    r = $urandom_range(0, 99);
    if (r >= 90) idle_cycles($urandom_range(8, 40));
    else if (r >= 60) idle_cycles($urandom_range(1, 3));
  endtask

  // Sample patterns: full random, clustered (many ties), rail values,
  // rising ramp, falling ramp.
  function automatic sample_t pick_sample(int mode, int idx, sample_t base);
    case (mode)
      1:       return sample_t'(base + $urandom_range(0, 7));
      2:       return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : sample_t'(0);
      3:       return sample_t'(base + idx * 37);
      4:       return sample_t'(base - idx * 37);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic int window_span(logic [WS_BITS-1:0] ws);
    if (ws == '0) return 1;
    if (ws > MAX_WINDOW_DEFAULT) return MAX_WINDOW_DEFAULT;
    return int'(ws);
  endfunction

  initial begin
    int                 sent;
    int                 count;
    int                 span;
    int                 mode;
    bit                 burst;
    sample_t            base;
    logic [WS_BITS-1:0] ws;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Read back the reset window size.
    cfg_access(1'b0, '0);

    // Window of one: every sample comes back doubled, both rails.
    set_window(1);
    push_sample('0);
    push_sample(SAMPLE_MAX);
    // Window of zero behaves as a window of one.
    set_window(0);
    push_sample(SAMPLE_MAX);
    push_sample(1);
    // Even window at the top rail: largest result.
    set_window(2);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MAX);
    // Odd window, unsorted arrival.
    set_window(3);
    push_sample(7);
    push_sample(SAMPLE_MAX);
    push_sample('0);
    // Shrink below the held count: the next sample closes a window of four.
    set_window(5);
    push_sample(100);
    push_sample(3000);
    push_sample(50);
    set_window(2);
    push_sample(2000);
    // Enlarge mid-window: collection runs on to six.
    set_window(3);
    push_sample(9);
    push_sample(1);
    set_window(6);
    push_sample(4000);
    push_sample('0);
    push_sample(12);
    push_sample(SAMPLE_MAX);

    // Random phases; a phase often ends mid-window so the next setting
    // grows or shrinks a partly filled window.
    sent = 0;
    while (sent < ITEMS) begin
      case ($urandom_range(0, 11))
        0:       ws = 0;
        1:       ws = 1;
        2:       ws = 2;
        3:       ws = 32;
        4:       ws = 31;
        5:       ws = WS_BITS'($urandom_range(33, 62));
        6:       ws = '1;
        7:       ws = WINDOW_SIZE_RESET;
        default: ws = WS_BITS'($urandom_range(3, 20));
      endcase
      set_window(ws);
      span  = window_span(ws);
      count = span * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, span);
      burst = ($urandom_range(0, 3) == 0);
      mode  = $urandom_range(0, 4);
      base  = sample_t'($urandom());
      for (int i = 0; i < count; i++) begin
        sender_gap(burst);
        push_sample(pick_sample(mode, i, base));
      end
      sent += count;
    end

    wait_idle();
    if (err_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
